// File: hw/rtl/pfxc_pkg.sv
// ----------------------------------------------------------------------------
// pfxc_pkg
// Shared widths, register codes and types of the packet feedback XOR cipher.
// ----------------------------------------------------------------------------
package pfxc_pkg;

  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int BYTES       = WORD_W / 8;
  localparam int COUNT_W     = 4;
  localparam int LEN_W       = 16;
  localparam int LMULT_W     = 32;
  localparam int KEY_ENTRIES = 16;
  localparam int KEY_IDX_W   = $clog2(KEY_ENTRIES);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // one key step and one feedback step per table entry
  localparam int STEP_W = $clog2(2 * KEY_ENTRIES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * KEY_ENTRIES - 1);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED        = 2'd0,
    REG_SEED_OFFSET = 2'd1,
    REG_KEY_MULT    = 2'd2,
    REG_LENGTH_MULT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KDF_IDLE,
    KDF_ADD,
    KDF_MUL_LO,
    KDF_CROSS_A,
    KDF_CROSS_B,
    KDF_SUM
  } kdf_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] seed_offset;
    logic [WORD_W-1:0] key_multiplier;
  } key_cfg_t;

  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] start_feedback;
  } key_status_t;

endpackage

// File: hw/rtl/pfxc_in_if.sv
// ----------------------------------------------------------------------------
// pfxc_in_if
// Input word channel: valid/ready plus one packet word and its framing.
// ----------------------------------------------------------------------------
interface pfxc_in_if;
  import pfxc_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [WORD_W-1:0]  data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               first_word;
  logic               last_word;
  logic [LEN_W-1:0]   packet_length;

  modport source (
    output valid, op, data_word, byte_count, first_word, last_word, packet_length,
    input  ready
  );

  modport sink (
    input  valid, op, data_word, byte_count, first_word, last_word, packet_length,
    output ready
  );

  modport monitor (
    input valid, ready, op, data_word, byte_count, first_word, last_word, packet_length
  );
endinterface

// File: hw/rtl/pfxc_out_if.sv
// ----------------------------------------------------------------------------
// pfxc_out_if
// Result word channel: valid/ready plus one transformed word.
// ----------------------------------------------------------------------------
interface pfxc_out_if;
  import pfxc_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  result_word;
  logic [COUNT_W-1:0] result_count;
  logic               result_last;

  modport source (
    output valid, result_word, result_count, result_last,
    input  ready
  );

  modport sink (
    input  valid, result_word, result_count, result_last,
    output ready
  );

  modport monitor (
    input valid, ready, result_word, result_count, result_last
  );
endinterface

// File: hw/rtl/pfxc_key_sched.sv
// ----------------------------------------------------------------------------
// pfxc_key_sched
// Key schedule: derives the 16-entry key table and the starting feedback word
// with one shared 32x32 multiplier, one mod-2^64 add-and-multiply per step.
// ----------------------------------------------------------------------------
module pfxc_key_sched (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  pfxc_pkg::key_cfg_t              cfg,
  input  logic [pfxc_pkg::KEY_IDX_W-1:0]  key_sel,
  output logic [pfxc_pkg::WORD_W-1:0]     key_word,
  output pfxc_pkg::key_status_t           status
);
  import pfxc_pkg::*;

  kdf_state_t state;
  kdf_state_t state_next;
  logic [STEP_W-1:0] step;

  logic [WORD_W-1:0] key_table [KEY_ENTRIES];
  logic [WORD_W-1:0] q_reg;
  logic [WORD_W-1:0] f_reg;
  logic [WORD_W-1:0] a_reg;
  logic [WORD_W-1:0] p_reg;
  logic [WORD_W-1:0] acc;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_out;
  logic [WORD_W-1:0] add_x;
  logic [WORD_W-1:0] add_y;
  logic [WORD_W-1:0] step_result;
  logic              feedback_step;
  logic              first_pair;

  // even steps extend the key chain, odd steps fold the new key into feedback
  assign feedback_step = step[0];
  assign first_pair    = (step[STEP_W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= KDF_ADD;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == KDF_SUM) begin
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      KDF_IDLE:    state_next = KDF_IDLE;
      KDF_ADD:     state_next = KDF_MUL_LO;
      KDF_MUL_LO:  state_next = KDF_CROSS_A;
      KDF_CROSS_A: state_next = KDF_CROSS_B;
      KDF_CROSS_B: state_next = KDF_SUM;
      KDF_SUM:     state_next = (step == LAST_STEP) ? KDF_IDLE : KDF_ADD;
      default:     state_next = KDF_IDLE;
    endcase
  end

  always_comb begin
    mul_a = a_reg[HALF_W-1:0];
    mul_b = cfg.key_multiplier[HALF_W-1:0];
    unique case (state)
      KDF_CROSS_A: mul_b = cfg.key_multiplier[WORD_W-1:HALF_W];
      KDF_CROSS_B: mul_a = a_reg[WORD_W-1:HALF_W];
      default: ;
    endcase
  end

  assign mul_out = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

  assign add_x = (!feedback_step && first_pair) ? cfg.seed_offset : q_reg;
  assign add_y = feedback_step ? (first_pair ? cfg.seed_offset : f_reg) : cfg.seed;

  assign step_result = {acc[WORD_W-1:HALF_W] + p_reg[HALF_W-1:0], acc[HALF_W-1:0]};

  always_ff @(posedge clk) begin
    case (state)
      KDF_ADD:    a_reg <= add_x + add_y;
      KDF_MUL_LO: p_reg <= mul_out;
      KDF_CROSS_A: begin
        acc   <= p_reg;
        p_reg <= {{HALF_W{1'b0}}, mul_out[HALF_W-1:0]};
      end
      KDF_CROSS_B: begin
        acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + p_reg[HALF_W-1:0];
        p_reg                <= {{HALF_W{1'b0}}, mul_out[HALF_W-1:0]};
      end
      KDF_SUM: begin
        if (feedback_step) begin
          f_reg <= step_result;
        end else begin
          q_reg                         <= step_result;
          key_table[step[STEP_W-1:1]] <= step_result;
        end
      end
      default: ;
    endcase
  end

  assign key_word              = key_table[key_sel];
  assign status.busy           = (state != KDF_IDLE);
  assign status.start_feedback = f_reg;

endmodule

// File: hw/rtl/packet_feedback_xor_cipher_core.sv
// ----------------------------------------------------------------------------
// packet_feedback_xor_cipher_core
// Word-serial packet cipher with key-table XOR and output/input feedback.
// ----------------------------------------------------------------------------
// Usage:
//   words   : packet words in, valid/ready. first_word loads the start feedback
//             and the key index from packet_length; op selects encrypt (0) or
//             decrypt (1) feedback.
//   results : one result word per input word, valid/ready, in order.
//   cfg_*   : single-cycle register writes, only while no packet is in flight.
// An input transfer passes one input register and one result register before
// result valid. Throughput is one word per cycle while results is ready and
// the key schedule is idle; the feedback word and key index close through one
// register each. After reset, and after any write to seed, seed_offset or
// key_multiplier, the key schedule runs 32 multiply steps on one 32x32
// multiplier with words.ready low. length_multiplier takes effect at once.
// When results stalls, the result register holds and the input register
// fills; words.ready drops once both are occupied.
// Reset clears both pipeline stages, the feedback word and the key index.
// ----------------------------------------------------------------------------
module packet_feedback_xor_cipher_core (
  input  logic                              clk,
  input  logic                              rst,
  pfxc_in_if.sink                           words,
  pfxc_out_if.source                        results,
  input  logic                              cfg_write,
  input  logic [pfxc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfxc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfxc_pkg::*;

  // configuration
  key_cfg_t           key_cfg;
  logic [LMULT_W-1:0] length_multiplier;
  logic               restart;

  key_status_t        key_status;
  logic [WORD_W-1:0]  key_word;

  // input register
  logic               s1_valid;
  logic               s1_op;
  logic [WORD_W-1:0]  s1_data;
  logic [COUNT_W-1:0] s1_count;
  logic               s1_first;
  logic               s1_last;
  logic [LEN_W-1:0]   s1_plen;

  // result register
  logic               out_valid;
  logic [WORD_W-1:0]  result_word;
  logic [COUNT_W-1:0] result_count;
  logic               result_last;

  // packet state
  logic [WORD_W-1:0]    feedback_word;
  logic [WORD_W-1:0]    feedback_word_next;
  logic [KEY_IDX_W-1:0] key_index;
  logic [KEY_IDX_W-1:0] key_index_next;

  logic                   in_xfer;
  logic                   s1_advance;
  logic [COUNT_W-1:0]     count_eff;
  logic [WORD_W-1:0]      byte_mask;
  logic [2*KEY_IDX_W-1:0] idx_prod;
  logic [KEY_IDX_W-1:0]   idx_use;
  logic [WORD_W-1:0]      fb_use;
  logic [WORD_W-1:0]      din;
  logic [WORD_W-1:0]      dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg.seed           <= '0;
      key_cfg.seed_offset    <= '0;
      key_cfg.key_multiplier <= WORD_W'(1);
      length_multiplier      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEED:        key_cfg.seed           <= cfg_data[WORD_W-1:0];
        REG_SEED_OFFSET: key_cfg.seed_offset    <= cfg_data[WORD_W-1:0];
        REG_KEY_MULT:    key_cfg.key_multiplier <= cfg_data[WORD_W-1:0];
        REG_LENGTH_MULT: length_multiplier      <= cfg_data[LMULT_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_reg_t'(cfg_index) != REG_LENGTH_MULT);

  pfxc_key_sched u_key_sched (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .cfg      (key_cfg),
    .key_sel  (idx_use),
    .key_word (key_word),
    .status   (key_status)
  );

  // handshake
  assign s1_advance  = s1_valid && (!out_valid || results.ready);
  assign words.ready = !key_status.busy && (!s1_valid || s1_advance);
  assign in_xfer     = words.valid && words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op    <= words.op;
      s1_data  <= words.data_word;
      s1_count <= words.byte_count;
      s1_first <= words.first_word;
      s1_last  <= words.last_word;
      s1_plen  <= words.packet_length;
    end
  end

  // zero or out-of-range counts mean a full word
  assign count_eff = (s1_count == '0 || s1_count > FULL_COUNT) ? FULL_COUNT : s1_count;

  always_comb begin
    for (int b = 0; b < BYTES; b++) begin
      byte_mask[8*b +: 8] = {8{COUNT_W'(b) < count_eff}};
    end
  end

  // only the low index bits of length * multiplier are kept
  assign idx_prod = {{KEY_IDX_W{1'b0}}, s1_plen[KEY_IDX_W-1:0]}
                  * {{KEY_IDX_W{1'b0}}, length_multiplier[KEY_IDX_W-1:0]};

  assign idx_use = s1_first ? idx_prod[KEY_IDX_W-1:0] : key_index;
  assign fb_use  = s1_first ? key_status.start_feedback : feedback_word;

  assign din  = s1_data & byte_mask;
  assign dout = (din ^ key_word ^ fb_use) & byte_mask;

  assign feedback_word_next = s1_op ? din : dout;
  assign key_index_next     = idx_use + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_word <= '0;
      key_index     <= '0;
    end else if (s1_advance) begin
      feedback_word <= feedback_word_next;
      key_index     <= key_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result_word  <= dout;
      result_count <= count_eff;
      result_last  <= s1_last;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_word  = result_word;
  assign results.result_count = result_count;
  assign results.result_last  = result_last;

endmodule

// File: hw/rtl/pfxc_checker.sv
// ----------------------------------------------------------------------------
// pfxc_checker
// Port-level checks of the cipher core, attached by bind.
// ----------------------------------------------------------------------------
module pfxc_checker (
  input logic                           clk,
  input logic                           rst,
  pfxc_in_if.sink                       words,
  pfxc_out_if.source                    results,
  input logic                           cfg_write,
  input logic [pfxc_pkg::CFG_IDX_W-1:0] cfg_index
);
  import pfxc_pkg::*;

  // a key register write starts the schedule, which blocks new words
  a_sched_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index != REG_LENGTH_MULT) |=> !words.ready)
    else $error("words.ready high right after a key register write");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.result_count != '0) && (results.result_count <= FULL_COUNT))
    else $error("result_count out of range");

  // bytes past the count are zero
  a_unused_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.result_count < FULL_COUNT)
      |-> ((results.result_word >> {results.result_count, 3'b000}) == '0))
    else $error("result_word has nonzero bytes beyond result_count");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready
      |=> results.valid && $stable(results.result_word) && $stable(results.result_last))
    else $error("stalled result changed");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result valid right after reset");

endmodule

bind packet_feedback_xor_cipher_core pfxc_checker u_pfxc_checker (
  .clk       (clk),
  .rst       (rst),
  .words     (words),
  .results   (results),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index)
);
